/* sv/k_weighted_sample_level_assert.svh */
// Assertion macros for the K-weighted sample level block.
`ifndef K_WEIGHTED_SAMPLE_LEVEL_ASSERT_SVH
`define K_WEIGHTED_SAMPLE_LEVEL_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define KWSL_ASSERT_NOW(name, clock, reset_n, cond, rhs) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (rhs)) \
        else $error("k_weighted_sample_level: assertion failed");

// Check a consequent in the cycle after its antecedent.
`define KWSL_ASSERT_NEXT(name, clock, reset_n, cond, rhs) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (rhs)) \
        else $error("k_weighted_sample_level: assertion failed");

`endif

/* sv/kwsl_pkg.sv */
`timescale 1ns / 1ps
// Types, filter coefficients and step tables for the K-weighted level block.
package kwsl_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic [2:0]         chan_t;
    typedef logic [3:0]         cfg_t;
    typedef logic signed [31:0] mul_a_t;
    typedef logic signed [32:0] mul_b_t;
    typedef logic signed [64:0] mul_p_t;
    typedef logic [3:0]         op_t;
    typedef logic [2:0]         src_t;
    typedef logic [1:0]         mode_t;

    localparam cfg_t    CFG_RESET  = 4'd2;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // Biquad coefficients, Q3.28 in a signed 32-bit word
    localparam mul_a_t SHELF_A1 = -32'sd453832898;
    localparam mul_a_t SHELF_A2 = 32'sd196623811;
    localparam mul_a_t SHELF_B0 = 32'sd412081942;
    localparam mul_a_t SHELF_B1 = -32'sd722546694;
    localparam mul_a_t SHELF_B2 = 32'sd321691121;
    localparam mul_a_t HP_A1    = -32'sd534199296;
    localparam mul_a_t HP_A2    = 32'sd265770496;
    localparam mul_a_t HP_B0    = 32'sd268435456;
    localparam mul_a_t HP_B1    = -32'sd536870912;
    localparam mul_a_t HP_B2    = 32'sd268435456;

    localparam mul_p_t ROUND_Q28 = 65'sd134217728;

    // 10*log10(2) in Q16; log2 offset 16 + log2(32767) in Q16 folded into the rounding term
    localparam mul_b_t  DB_PER_OCTAVE_Q16 = 33'sd197283;
    localparam mul_p_t  DB_ROUND = 65'sd8388608 - 65'sd2031613 * 65'sd197283;
    localparam sample_t LEVEL_BIAS_Q8 = -16'sd177;
    localparam mul_p_t  LEVEL_MAX = 65'sd32767;
    localparam mul_p_t  LEVEL_MIN = -65'sd32768;

    localparam logic [3:0] SQ_LAST = 4'd15;

    // Filter steps, one coefficient product each
    localparam op_t OP_SHELF_A1 = 4'd0;
    localparam op_t OP_SHELF_A2 = 4'd1;
    localparam op_t OP_SHELF_B0 = 4'd2;
    localparam op_t OP_SHELF_B1 = 4'd3;
    localparam op_t OP_SHELF_B2 = 4'd4;
    localparam op_t OP_HP_A1    = 4'd5;
    localparam op_t OP_HP_A2    = 4'd6;
    localparam op_t OP_HP_B0    = 4'd7;
    localparam op_t OP_HP_B1    = 4'd8;
    localparam op_t OP_HP_B2    = 4'd9;

    localparam src_t SRC_Z1  = 3'd0;
    localparam src_t SRC_Z2  = 3'd1;
    localparam src_t SRC_H1  = 3'd2;
    localparam src_t SRC_H2  = 3'd3;
    localparam src_t SRC_ACC = 3'd4;

    localparam mode_t MODE_SUB  = 2'd0;
    localparam mode_t MODE_ADD  = 2'd1;
    localparam mode_t MODE_LOAD = 2'd2;

    function automatic mul_a_t op_coef(input op_t op);
        mul_a_t c;
        unique case (op)
            OP_SHELF_A1: c = SHELF_A1;
            OP_SHELF_A2: c = SHELF_A2;
            OP_SHELF_B0: c = SHELF_B0;
            OP_SHELF_B1: c = SHELF_B1;
            OP_SHELF_B2: c = SHELF_B2;
            OP_HP_A1:    c = HP_A1;
            OP_HP_A2:    c = HP_A2;
            OP_HP_B0:    c = HP_B0;
            OP_HP_B1:    c = HP_B1;
            OP_HP_B2:    c = HP_B2;
            default:     c = '0;
        endcase
        return c;
    endfunction

    function automatic src_t op_src(input op_t op);
        src_t s;
        unique case (op)
            OP_SHELF_A1, OP_SHELF_B1: s = SRC_Z1;
            OP_SHELF_A2, OP_SHELF_B2: s = SRC_Z2;
            OP_HP_A1, OP_HP_B1:       s = SRC_H1;
            OP_HP_A2, OP_HP_B2:       s = SRC_H2;
            default:                  s = SRC_ACC;
        endcase
        return s;
    endfunction

    function automatic mode_t op_mode(input op_t op);
        mode_t m;
        unique case (op)
            OP_SHELF_A1, OP_SHELF_A2, OP_HP_A1, OP_HP_A2: m = MODE_SUB;
            OP_SHELF_B0, OP_HP_B0:                        m = MODE_LOAD;
            default:                                      m = MODE_ADD;
        endcase
        return m;
    endfunction

endpackage

/* sv/kwsl_in_if.sv */
`timescale 1ns / 1ps
// Input channel: one PCM sample word with its channel index.
interface kwsl_in_if import kwsl_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_value;
    chan_t   channel_index;

    modport source (output valid, output sample_value, output channel_index, input ready);
    modport sink   (input valid, input sample_value, input channel_index, output ready);
endinterface

/* sv/kwsl_out_if.sv */
`timescale 1ns / 1ps
// Output channel: one level word per accepted sample.
interface kwsl_out_if import kwsl_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t level_db;
    chan_t   result_channel;
    logic    channel_ok;

    modport source (output valid, output level_db, output result_channel, output channel_ok,
                    input ready);
    modport sink   (input valid, input level_db, input result_channel, input channel_ok,
                    output ready);
endinterface

/* sv/kwsl_mul.sv */
`timescale 1ns / 1ps
// Shared signed 32x33 multiplier with a registered product.
module kwsl_mul import kwsl_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  mul_a_t a,
    input  mul_b_t b,
    output mul_p_t prod
);

    mul_p_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mul_p_t'(a) * mul_p_t'(b);
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/kwsl_regs.sv */
`timescale 1ns / 1ps
// Per-channel delay elements of both biquads, with the delay-line shift on write.
module kwsl_regs import kwsl_pkg::*; #(
    parameter int NUM_CH = 8,
    parameter int SB     = 48,
    localparam int IW    = (NUM_CH > 1) ? $clog2(NUM_CH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IW-1:0]        idx,
    input  logic                 wr_en,
    input  logic signed [SB-1:0] w1,
    input  logic signed [SB-1:0] w2,
    output logic signed [SB-1:0] z1,
    output logic signed [SB-1:0] z2,
    output logic signed [SB-1:0] h1,
    output logic signed [SB-1:0] h2
);

    logic signed [SB-1:0] z1_reg [NUM_CH];
    logic signed [SB-1:0] z2_reg [NUM_CH];
    logic signed [SB-1:0] h1_reg [NUM_CH];
    logic signed [SB-1:0] h2_reg [NUM_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
                h1_reg[i] <= '0;
                h2_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            // advance both delay lines of the channel
            z2_reg[idx] <= z1_reg[idx];
            z1_reg[idx] <= w1;
            h2_reg[idx] <= h1_reg[idx];
            h1_reg[idx] <= w2;
        end
    end

    assign z1 = z1_reg[idx];
    assign z2 = z2_reg[idx];
    assign h1 = h1_reg[idx];
    assign h2 = h2_reg[idx];

endmodule

/* sv/k_weighted_sample_level.sv */
`timescale 1ns / 1ps
// K-weighted instant level per channel: shelf and high-pass biquads, then log2 to dB.
// For a channel in use (48-bit state by default): 10 products on the shared 32x33 multiplier,
// each a low multiply, high multiply, sum and accumulate step, then a normalize, then 16
// squaring passes of a multiply and a step each. A channel out of use goes straight to result.
// One word in flight: a new word is taken once the result word is loaded, which a stall delays;
// reset clears all channel state and sets the channels in use (chan_use_reg) to 2.
module k_weighted_sample_level import kwsl_pkg::*; #(
    parameter int MAX_CHANNELS = 8,
    parameter int STATE_BITS   = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  cfg_t              cfg_wr_data,
    kwsl_in_if.sink           sample_in,
    kwsl_out_if.source        level_out
);

    localparam int SB = STATE_BITS;
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EW = $clog2(STATE_BITS);
    localparam int AW = STATE_BITS + 1;
    localparam int SW = STATE_BITS + 5;
    localparam int PW = STATE_BITS + 33;
    localparam logic signed [SB-1:0] ST_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] ST_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [SB-1:0] NORM_FLOOR = {{(SB-17){1'b0}}, 1'b1, 16'h0000};

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_LO  = 4'd1;
    localparam logic [3:0] ST_MUL_HI  = 4'd2;
    localparam logic [3:0] ST_SUM     = 4'd3;
    localparam logic [3:0] ST_ACC     = 4'd4;
    localparam logic [3:0] ST_ABS     = 4'd5;
    localparam logic [3:0] ST_NORM    = 4'd6;
    localparam logic [3:0] ST_SQ_MUL  = 4'd7;
    localparam logic [3:0] ST_SQ_STEP = 4'd8;
    localparam logic [3:0] ST_DB_MUL  = 4'd9;
    localparam logic [3:0] ST_DB_SUM  = 4'd10;
    localparam logic [3:0] ST_FIN     = 4'd11;

    logic [3:0] state_reg, state_next;
    op_t        op_reg;
    logic [3:0] sq_cnt_reg;
    cfg_t       chan_use_reg;
    logic       out_valid_reg;

    chan_t                ch_reg;
    logic                 ok_reg;
    logic signed [SB-1:0] acc_reg;
    logic signed [SB-1:0] w1_reg;
    logic signed [SB-1:0] w2_reg;
    logic signed [SB-1:0] p_reg;
    mul_p_t               lo_reg;
    logic [SB-1:0]        norm_reg;
    logic [EW-1:0]        exp_reg;
    logic [30:0]          x_reg;
    logic [15:0]          frac_reg;
    sample_t              level_reg;
    sample_t              lvl_out_reg;
    chan_t                rch_out_reg;
    logic                 ok_out_reg;

    logic                 in_fire;
    logic                 in_ok;
    logic [14:0]          mag;
    sample_t              neg_sample;
    logic                 load_out;
    logic                 regs_wr;
    logic signed [SB-1:0] z1, z2, h1, h2;
    logic signed [SB-1:0] operand;
    mul_a_t               mul_a;
    mul_b_t               mul_b;
    logic                 mul_en;
    mul_p_t               mul_prod;
    logic signed [PW-1:0] sum_full;
    logic signed [SW-1:0] rnd;
    logic signed [SB-1:0] p_new;
    logic signed [AW-1:0] acc_ext;
    logic signed [AW-1:0] p_ext;
    logic signed [SB-1:0] acc_new;
    logic [SB-1:0]        abs_val;
    logic [31:0]          sq_bits;
    mul_p_t               db_shift;
    mul_p_t               db_lvl;
    sample_t              db_sat;

    function automatic logic signed [SB-1:0] sat_sum(input logic signed [AW-1:0] v);
        logic signed [SB-1:0] r;
        if (v[AW-1] != v[SB-1])
        begin
            r = v[AW-1] ? ST_MIN : ST_MAX;
        end
        else
        begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    assign in_fire = sample_in.valid && sample_in.ready;
    assign sample_in.ready = (state_reg == ST_IDLE);

    assign in_ok = ({1'b0, sample_in.channel_index} < chan_use_reg) &&
                   (32'(sample_in.channel_index) < 32'(MAX_CHANNELS));

    assign neg_sample = -sample_in.sample_value;

    // rectify; the most negative sample saturates
    always_comb
    begin
        if (!sample_in.sample_value[15])
        begin
            mag = sample_in.sample_value[14:0];
        end
        else if (sample_in.sample_value == SAMPLE_MIN)
        begin
            mag = 15'h7fff;
        end
        else
        begin
            mag = neg_sample[14:0];
        end
    end

    // ------------------------------------------------------------------
    // Channel state and shared multiplier
    // ------------------------------------------------------------------
    assign regs_wr = (state_reg == ST_ACC) && (op_reg == OP_HP_B2);

    kwsl_regs #(
        .NUM_CH (MAX_CHANNELS),
        .SB     (STATE_BITS)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (CW'(ch_reg)),
        .wr_en (regs_wr),
        .w1    (w1_reg),
        .w2    (w2_reg),
        .z1    (z1),
        .z2    (z2),
        .h1    (h1),
        .h2    (h2)
    );

    always_comb
    begin
        unique case (op_src(op_reg))
            SRC_Z1:  operand = z1;
            SRC_Z2:  operand = z2;
            SRC_H1:  operand = h1;
            SRC_H2:  operand = h2;
            SRC_ACC: operand = acc_reg;
            default: operand = acc_reg;
        endcase
    end

    always_comb
    begin
        mul_a = op_coef(op_reg);
        mul_b = {1'b0, operand[31:0]};
        unique case (state_reg)
            ST_MUL_HI:
            begin
                mul_b = mul_b_t'($signed(operand[SB-1:32]));
            end
            ST_SQ_MUL:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {2'b00, x_reg};
            end
            ST_DB_MUL:
            begin
                mul_a = mul_a_t'({exp_reg, frac_reg});
                mul_b = DB_PER_OCTAVE_Q16;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_en = (state_reg == ST_MUL_LO) || (state_reg == ST_MUL_HI) ||
                    (state_reg == ST_SQ_MUL) || (state_reg == ST_DB_MUL);

    kwsl_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // ------------------------------------------------------------------
    // Product assembly, accumulate, log2 and dB
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_full = (PW'(mul_prod) <<< 32) + PW'(lo_reg) + PW'(ROUND_Q28);
        rnd = sum_full[PW-1:28];
        if (rnd > SW'(ST_MAX))
        begin
            p_new = ST_MAX;
        end
        else if (rnd < SW'(ST_MIN))
        begin
            p_new = ST_MIN;
        end
        else
        begin
            p_new = rnd[SB-1:0];
        end
    end

    assign acc_ext = AW'(acc_reg);
    assign p_ext   = AW'(p_reg);

    always_comb
    begin
        unique case (op_mode(op_reg))
            MODE_SUB:  acc_new = sat_sum(acc_ext - p_ext);
            MODE_ADD:  acc_new = sat_sum(acc_ext + p_ext);
            MODE_LOAD: acc_new = p_reg;
            default:   acc_new = p_reg;
        endcase
    end

    always_comb
    begin
        abs_val = acc_reg[SB-1] ? SB'(-acc_reg) : acc_reg;
        if (abs_val < NORM_FLOOR)
        begin
            abs_val = NORM_FLOOR;
        end
    end

    assign sq_bits = mul_prod[61:30];

    always_comb
    begin
        db_shift = (mul_prod + DB_ROUND) >>> 24;
        db_lvl   = db_shift + 65'(LEVEL_BIAS_Q8);
        if (db_lvl > LEVEL_MAX)
        begin
            db_sat = 16'sh7fff;
        end
        else if (db_lvl < LEVEL_MIN)
        begin
            db_sat = 16'sh8000;
        end
        else
        begin
            db_sat = db_lvl[15:0];
        end
    end

    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || level_out.ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    state_next = in_ok ? ST_MUL_LO : ST_FIN;
                end
            end
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_SUM;
            ST_SUM:     state_next = ST_ACC;
            ST_ACC:     state_next = (op_reg == OP_HP_B2) ? ST_ABS : ST_MUL_LO;
            ST_ABS:     state_next = ST_NORM;
            ST_NORM:
            begin
                if (norm_reg[SB-1])
                begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL:  state_next = ST_SQ_STEP;
            ST_SQ_STEP: state_next = (sq_cnt_reg == SQ_LAST) ? ST_DB_MUL : ST_SQ_MUL;
            ST_DB_MUL:  state_next = ST_DB_SUM;
            ST_DB_SUM:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SHELF_A1;
            sq_cnt_reg    <= '0;
            chan_use_reg  <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                chan_use_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                op_reg <= OP_SHELF_A1;
            end
            else if (state_reg == ST_ACC && op_reg != OP_HP_B2)
            begin
                op_reg <= op_reg + op_t'(1);
            end
            if (state_reg == ST_NORM)
            begin
                sq_cnt_reg <= '0;
            end
            else if (state_reg == ST_SQ_STEP)
            begin
                sq_cnt_reg <= sq_cnt_reg + 4'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (level_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    ch_reg    <= sample_in.channel_index;
                    ok_reg    <= in_ok;
                    acc_reg   <= SB'({mag, 16'h0000});
                    level_reg <= '0;
                end
            end
            ST_MUL_HI:
            begin
                lo_reg <= mul_prod;
            end
            ST_SUM:
            begin
                p_reg <= p_new;
            end
            ST_ACC:
            begin
                acc_reg <= acc_new;
                if (op_reg == OP_SHELF_A2)
                begin
                    w1_reg <= acc_new;
                end
                if (op_reg == OP_HP_A2)
                begin
                    w2_reg <= acc_new;
                end
            end
            ST_ABS:
            begin
                norm_reg <= abs_val;
                exp_reg  <= EW'(SB - 1);
            end
            ST_NORM:
            begin
                // shift the top set bit up to the MSB, a byte at a time where possible
                if (norm_reg[SB-1])
                begin
                    x_reg    <= norm_reg[SB-1 -: 31];
                    frac_reg <= '0;
                end
                else if (norm_reg[SB-1 -: 8] == 8'h00)
                begin
                    norm_reg <= norm_reg << 8;
                    exp_reg  <= exp_reg - EW'(8);
                end
                else
                begin
                    norm_reg <= norm_reg << 1;
                    exp_reg  <= exp_reg - EW'(1);
                end
            end
            ST_SQ_STEP:
            begin
                frac_reg <= {frac_reg[14:0], sq_bits[31]};
                x_reg    <= sq_bits[31] ? sq_bits[31:1] : sq_bits[30:0];
            end
            ST_DB_SUM:
            begin
                level_reg <= db_sat;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    lvl_out_reg <= level_reg;
                    rch_out_reg <= ch_reg;
                    ok_out_reg  <= ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign level_out.valid          = out_valid_reg;
    assign level_out.level_db       = lvl_out_reg;
    assign level_out.result_channel = rch_out_reg;
    assign level_out.channel_ok     = ok_out_reg;

endmodule

/* sv/kwsl_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the K-weighted level block, bound to the top level.
`include "k_weighted_sample_level_assert.svh"

module kwsl_checker import kwsl_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t level_db,
    input chan_t   result_channel,
    input logic    channel_ok
);

    logic [19:0] out_word;

    assign out_word = {level_db, result_channel, channel_ok};

    // a stalled result word stays up
    `KWSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `KWSL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_word))
    // a channel out of use reports level zero
    `KWSL_ASSERT_NOW(a_off_zero, clk, rst_n, out_valid && !channel_ok, level_db == 16'sh0000)
    // one word at a time: busy right after an accept
    `KWSL_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind k_weighted_sample_level kwsl_checker u_kwsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_in.valid),
    .in_ready       (sample_in.ready),
    .out_valid      (level_out.valid),
    .out_ready      (level_out.ready),
    .level_db       (level_out.level_db),
    .result_channel (level_out.result_channel),
    .channel_ok     (level_out.channel_ok)
);
